/* design/urfm_pkg.sv */
// Shared types and constants for the UART receive FIFO register model.
package urfm_pkg;

   localparam int FIFO_DEPTH_DEFAULT = 256;

   localparam int OFFSET_W   = 28;
   localparam int BYTE_W     = 8;
   localparam int READ_W     = 32;
   localparam int ACTION_W   = 2;
   localparam int REQ_TDATA_W = ((OFFSET_W + BYTE_W + 7) / 8) * 8;
   // Result fields ahead of free_space: read_data, tx_valid, tx_byte, rx_dropped.
   localparam int RSP_FIXED_W = READ_W + 1 + BYTE_W + 1;

   localparam logic [OFFSET_W-1:0] OFF_TX   = 28'h0840020;
   localparam logic [OFFSET_W-1:0] OFF_RX   = 28'h0840024;
   localparam logic [OFFSET_W-1:0] OFF_STAT = 28'h0840010;
   // Page match compares offset bits above the low byte.
   localparam logic [OFFSET_W-9:0] PAGE_TAG = 20'h08400;
   localparam logic [READ_W-1:0]   STAT_BASE = 32'h0000_0006;
   localparam logic [READ_W-1:0]   ALL_ONES  = 32'hFFFF_FFFF;

   typedef enum logic [ACTION_W-1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_RECV  = 2'd2
   } action_type;

   typedef struct packed {
      logic [READ_W-1:0] read_data;
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              rx_dropped;
   } result_type;

   typedef struct packed {
      logic       pop;
      result_type res;
   } stage_meta_type;

endpackage

/* design/uart_rx_fifo_register_model.sv */
// Top level of the UART register window with its receive FIFO.
// A result beat passes the control stage register, then the skid buffer's main register, before it is offered.
// Throughput: one beat per cycle while rsp_tready is high, set by the pointer update and one RAM port pair.
// Reset clears pointers, fill count and all valid flags; FIFO storage is not cleared,
// since a pop only ever reads an entry that was pushed earlier.
module uart_rx_fifo_register_model #(
   parameter int FIFO_DEPTH = urfm_pkg::FIFO_DEPTH_DEFAULT,
   localparam int AW    = $clog2(FIFO_DEPTH),
   localparam int CW    = $clog2(FIFO_DEPTH + 1),
   localparam int RSP_W = ((urfm_pkg::RSP_FIXED_W + CW + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // offset [27:0], byte_in [35:28], zero pad above
   input  logic [urfm_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action [1:0]: read, write or byte received from the line
   input  logic [urfm_pkg::ACTION_W-1:0]    req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_data [31:0], tx_valid, tx_byte, rx_dropped, free_space, zero pad above
   output logic [RSP_W-1:0]                 rsp_tdata
);

   logic                        ram_wr_en, ram_rd_en;
   logic [AW-1:0]               ram_wr_addr, ram_rd_addr;
   logic [urfm_pkg::BYTE_W-1:0] ram_wr_data, ram_rd_data;
   logic                        s1_valid, s1_ready;
   urfm_pkg::result_type        s1_res;
   logic [CW-1:0]               s1_free;

   // Decode the beat, move the FIFO pointers and issue the RAM access in the
   // acceptance cycle; the popped byte joins the result in the cycle after.
   urfm_ctrl #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_action   (urfm_pkg::action_type'(req_tuser)),
      .in_offset   (req_tdata[urfm_pkg::OFFSET_W-1:0]),
      .in_byte     (req_tdata[urfm_pkg::OFFSET_W +: urfm_pkg::BYTE_W]),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .out_valid   (s1_valid),
      .out_ready   (s1_ready),
      .out_res     (s1_res),
      .out_free    (s1_free)
   );

   // Push and pop never touch one entry together: a pop needs data and a
   // push needs room, so both pointers differ whenever both are live.
   urfm_ram #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Skid buffer: its ready is a flop, so rsp_tready never reaches req_tready
   // combinationally and a waiting result does not block the next request.
   urfm_out #(
      .FSW (CW)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid),
      .in_ready   (s1_ready),
      .in_res     (s1_res),
      .in_free    (s1_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* design/urfm_ram.sv */
// Receive FIFO storage: one write port, one registered read port.
module urfm_ram #(
   parameter int FIFO_DEPTH = urfm_pkg::FIFO_DEPTH_DEFAULT,
   localparam int AW = $clog2(FIFO_DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [urfm_pkg::BYTE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [urfm_pkg::BYTE_W-1:0] rd_data
);

   logic [urfm_pkg::BYTE_W-1:0] mem_q [FIFO_DEPTH];
   logic [urfm_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
   end

   // Hold read data until the next read so a stalled result keeps its byte.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_q[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/urfm_ctrl.sv */
// Register decode, FIFO pointer update and the stage that meets the RAM read.
module urfm_ctrl #(
   parameter int FIFO_DEPTH = urfm_pkg::FIFO_DEPTH_DEFAULT,
   localparam int AW = $clog2(FIFO_DEPTH),
   localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  urfm_pkg::action_type          in_action,
   input  logic [urfm_pkg::OFFSET_W-1:0] in_offset,
   input  logic [urfm_pkg::BYTE_W-1:0]   in_byte,
   output logic                          ram_wr_en,
   output logic [AW-1:0]                 ram_wr_addr,
   output logic [urfm_pkg::BYTE_W-1:0]   ram_wr_data,
   output logic                          ram_rd_en,
   output logic [AW-1:0]                 ram_rd_addr,
   input  logic [urfm_pkg::BYTE_W-1:0]   ram_rd_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output urfm_pkg::result_type          out_res,
   output logic [CW-1:0]                 out_free
);

   logic [AW-1:0] write_index_ff, write_index_in;
   logic [AW-1:0] read_index_ff, read_index_in;
   logic [CW-1:0] fill_count_ff, fill_count_in;
   logic          s1_valid_ff, s1_valid_in;
   urfm_pkg::stage_meta_type s1_meta_ff, meta_in;
   logic [CW-1:0] s1_free_ff, free_in;
   logic          accept, push, pop, has_data, is_full;

   assign in_ready = !s1_valid_ff || out_ready;
   assign accept   = in_valid && in_ready;
   assign has_data = (fill_count_ff != '0);
   assign is_full  = (fill_count_ff == CW'(FIFO_DEPTH));

   always_comb begin
      meta_in = '0;
      push    = 1'b0;
      pop     = 1'b0;
      unique case (in_action)
         urfm_pkg::ACT_READ: begin
            priority if (in_offset == urfm_pkg::OFF_STAT) begin
               meta_in.res.read_data = urfm_pkg::STAT_BASE | urfm_pkg::READ_W'(has_data);
            end else if (in_offset == urfm_pkg::OFF_RX) begin
               // Empty FIFO: read zero, leave pointers alone.
               pop = has_data;
            end else if (in_offset[urfm_pkg::OFFSET_W-1:8] == urfm_pkg::PAGE_TAG) begin
               meta_in.res.read_data = urfm_pkg::ALL_ONES;
            end else begin
               meta_in.res.read_data = '0;
            end
         end
         urfm_pkg::ACT_WRITE: begin
            if (in_offset == urfm_pkg::OFF_TX) begin
               meta_in.res.tx_valid = 1'b1;
               meta_in.res.tx_byte  = in_byte;
            end
         end
         urfm_pkg::ACT_RECV: begin
            push                   = !is_full;
            meta_in.res.rx_dropped = is_full;
         end
         default: begin
         end
      endcase
      meta_in.pop = pop;
   end

   always_comb begin
      write_index_in = write_index_ff;
      read_index_in  = read_index_ff;
      fill_count_in  = fill_count_ff;
      if (accept && push) begin
         write_index_in = (write_index_ff == AW'(FIFO_DEPTH - 1)) ? '0 : write_index_ff + 1'b1;
         fill_count_in  = fill_count_ff + 1'b1;
      end
      if (accept && pop) begin
         read_index_in = (read_index_ff == AW'(FIFO_DEPTH - 1)) ? '0 : read_index_ff + 1'b1;
         fill_count_in = fill_count_ff - 1'b1;
      end
      free_in = CW'(FIFO_DEPTH) - fill_count_in;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff <= '0;
         read_index_ff  <= '0;
         fill_count_ff  <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         write_index_ff <= write_index_in;
         read_index_ff  <= read_index_in;
         fill_count_ff  <= fill_count_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= meta_in;
         s1_free_ff <= free_in;
      end
   end

   assign ram_wr_en   = accept && push;
   assign ram_wr_addr = write_index_ff;
   assign ram_wr_data = in_byte;
   assign ram_rd_en   = accept && pop;
   assign ram_rd_addr = read_index_ff;

   always_comb begin
      out_res = s1_meta_ff.res;
      if (s1_meta_ff.pop) begin
         out_res.read_data = urfm_pkg::READ_W'(ram_rd_data);
      end
   end

   assign out_valid = s1_valid_ff;
   assign out_free  = s1_free_ff;

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CW'(FIFO_DEPTH))
      else $error("fill count above depth");

   a_empty_ptrs : assert property (@(posedge clock) disable iff (reset)
      fill_count_ff == '0 |-> write_index_ff == read_index_ff)
      else $error("empty FIFO with diverged pointers");

   a_no_push_pop : assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("push and pop on one beat");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_ready |=> s1_valid_ff && $stable(s1_free_ff) && $stable(out_res))
      else $error("stalled stage lost its result");

   a_free_track : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_free_ff == CW'(FIFO_DEPTH) - fill_count_ff)
      else $error("free space out of step with fill count");

endmodule

/* design/urfm_out.sv */
// Two-entry skid buffer driving the result stream.
module urfm_out #(
   parameter int FSW = $clog2(urfm_pkg::FIFO_DEPTH_DEFAULT + 1),
   localparam int RSP_W = ((urfm_pkg::RSP_FIXED_W + FSW + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  urfm_pkg::result_type in_res,
   input  logic [FSW-1:0]       in_free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   urfm_pkg::result_type main_res_ff, skid_res_ff;
   logic [FSW-1:0]       main_free_ff, skid_free_ff;
   logic                 in_fire, out_fire, load_main, load_skid, pull_skid;

   assign in_ready = !skid_valid_ff;
   assign in_fire  = in_valid && !skid_valid_ff;
   assign out_fire = main_valid_ff && rsp_tready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      load_main     = 1'b0;
      load_skid     = 1'b0;
      pull_skid     = 1'b0;
      priority if (skid_valid_ff) begin
         if (out_fire) begin
            pull_skid     = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (in_fire) begin
         if (!main_valid_ff || out_fire) begin
            load_main     = 1'b1;
            main_valid_in = 1'b1;
         end else begin
            load_skid     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (out_fire) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_main) begin
         main_res_ff  <= in_res;
         main_free_ff <= in_free;
      end else if (pull_skid) begin
         main_res_ff  <= skid_res_ff;
         main_free_ff <= skid_free_ff;
      end
      if (load_skid) begin
         skid_res_ff  <= in_res;
         skid_free_ff <= in_free;
      end
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = RSP_W'({main_free_ff, main_res_ff.rx_dropped, main_res_ff.tx_byte,
                               main_res_ff.tx_valid, main_res_ff.read_data});

endmodule
